>>> rtl/core/hhp_pkg.sv
`timescale 1ns / 1ps
package hhp_pkg;

  localparam int HEAD_W    = 15;
  localparam int EL_W      = 16;
  localparam int GAIN_W    = 18;
  localparam int LIM_W     = 15;
  localparam int OUT_W     = 16;
  localparam int ERR_W     = 24;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int KD_W      = GAIN_W + 10;
  localparam int ACC_W     = DIFF_W + KD_W + 1;
  localparam int SUM_W     = ACC_W + 1;
  localparam int HCMP_W    = 18;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 2'd3;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam int CORR_MAX = 32767;
  localparam int CORR_MIN = -32768;
  localparam int ERR_MAX  = 8388607;
  localparam int ERR_MIN  = -8388608;
  localparam logic signed [OUT_W-1:0] ONE_Q13 = 16'sd8192;

  typedef struct packed {
    logic              cmd;
    logic [HEAD_W-1:0] heading;
    logic [EL_W-1:0]   elapsed_ms;
  } hhp_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] correction;
    logic signed [OUT_W-1:0] drive_left;
    logic signed [OUT_W-1:0] drive_right;
    logic signed [ERR_W-1:0] heading_error;
  } hhp_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_MUL,
    S_POST,
    S_DIV,
    S_SUM,
    S_LOAD
  } hhp_state_t;

  typedef enum logic [1:0] {
    OP_PROP,
    OP_INTEG,
    OP_DERIV
  } hhp_op_t;

endpackage

>>> rtl/core/hhp_if.sv
`timescale 1ns / 1ps
interface hhp_in_if;
  import hhp_pkg::*;

  logic    valid;
  logic    ready;
  hhp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hhp_out_if;
  import hhp_pkg::*;

  logic     valid;
  logic     ready;
  hhp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/heading_hold_pid.sv
`timescale 1ns / 1ps
// Heading-hold PID controller.
// in_ch carries one item per transfer: cmd start (snap heading to the nearest
// quadrant as target, clear integral and wrap count) or sample (unwrap the
// heading and run the PID). out_ch returns one result per item: correction,
// drive_left, drive_right and heading_error. The user must write gains and
// the integral limit through cfg_we / cfg_idx / cfg_wdata while no item is
// in flight; the block itself does not enforce this. A start item goes
// straight to S_LOAD. A sample runs on one shared shift-add multiplier (one
// gain bit per cycle, for the proportional and integral products and then
// the derivative gain times 1000) and then a restoring divider by
// elapsed_ms (one quotient bit per cycle); S_SUM saturates the sum and
// S_LOAD writes the result to the output register once it is free.
// One item is processed at a time; the next item is taken in the cycle after
// the result reaches the output register, even while that result waits.
// A stalled receiver holds out_ch payload and valid until the transfer.
// Reset (rst_n low at a clock edge) clears the gains, the controller state
// and the output valid.
module heading_hold_pid #(
  parameter int WRAP_BITS         = 8,
  parameter int HEADING_FRAC_BITS = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hhp_in_if.sink                        in_ch,
  hhp_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [hhp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [hhp_pkg::GAIN_W-1:0]    cfg_wdata
);
  import hhp_pkg::*;

  localparam int SHIFT_Q = 3 + HEADING_FRAC_BITS;
  localparam int TGT_W   = 9 + HEADING_FRAC_BITS;
  localparam int LAST_W  = (TGT_W > HEAD_W) ? TGT_W : HEAD_W;
  localparam int UNW_RAW = WRAP_BITS + 11 + HEADING_FRAC_BITS;
  localparam int UNW_W   = (UNW_RAW > ERR_W + 2) ? UNW_RAW : ERR_W + 2;
  localparam int DIV_W   = ACC_W - SHIFT_Q;

  localparam logic [HCMP_W-1:0] DEG45  = HCMP_W'(45 << HEADING_FRAC_BITS);
  localparam logic [HCMP_W-1:0] DEG135 = HCMP_W'(135 << HEADING_FRAC_BITS);
  localparam logic [HCMP_W-1:0] DEG225 = HCMP_W'(225 << HEADING_FRAC_BITS);
  localparam logic [HCMP_W-1:0] DEG315 = HCMP_W'(315 << HEADING_FRAC_BITS);
  localparam logic signed [HCMP_W-1:0] DEG180_S = HCMP_W'(180 << HEADING_FRAC_BITS);
  localparam logic [TGT_W-1:0] TGT_90  = TGT_W'(90 << HEADING_FRAC_BITS);
  localparam logic [TGT_W-1:0] TGT_180 = TGT_W'(180 << HEADING_FRAC_BITS);
  localparam logic [TGT_W-1:0] TGT_270 = TGT_W'(270 << HEADING_FRAC_BITS);

  localparam logic signed [UNW_W-1:0] ERR_HI = UNW_W'(ERR_MAX);
  localparam logic signed [UNW_W-1:0] ERR_LO = UNW_W'(ERR_MIN);
  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(CORR_MAX);
  localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(CORR_MIN);
  localparam logic signed [OUT_W:0]   DRV_HI = (OUT_W + 1)'(CORR_MAX);
  localparam logic signed [OUT_W:0]   DRV_LO = (OUT_W + 1)'(CORR_MIN);
  localparam logic signed [ACC_W-1:0] HALF_Q = ACC_W'(1) << (SHIFT_Q - 1);

  // configuration
  logic [GAIN_W-1:0] gain_prop_r, gain_integ_r, gain_deriv_r;
  logic [LIM_W-1:0]  integ_limit_r;

  // controller state
  hhp_state_t                 state_r, state_nxt;
  hhp_op_t                    op_r, op_nxt;
  logic [TGT_W-1:0]           tgt_r, tgt_nxt;
  logic [LAST_W-1:0]          last_r, last_nxt;
  logic signed [WRAP_BITS-1:0] wrap_r, wrap_nxt;
  logic signed [OUT_W-1:0]    integ_r, integ_nxt;
  logic signed [ERR_W-1:0]    prev_r, prev_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // datapath
  logic [HEAD_W-1:0]          h_r, h_nxt;
  logic [EL_W-1:0]            el_r, el_nxt;
  logic                       start_r, start_nxt;
  logic signed [ERR_W-1:0]    err_r, err_nxt;
  logic signed [DIFF_W-1:0]   d_r, d_nxt;
  logic signed [ACC_W-1:0]    mc_r, mc_nxt;
  logic [KD_W-1:0]            mp_r, mp_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0]    prop_r, prop_nxt;
  logic signed [ACC_W-1:0]    pi_r, pi_nxt;
  logic                       neg_r, neg_nxt;
  logic [DIV_W-1:0]           dvd_r, dvd_nxt;
  logic [EL_W-1:0]            rem_r, rem_nxt;
  logic signed [OUT_W-1:0]    corr_r, corr_nxt;
  hhp_out_t                   out_r, out_nxt;

  // combinational helpers
  logic [HCMP_W-1:0]          h_in_ext;
  logic [TGT_W-1:0]           snap_tgt;
  logic signed [HCMP_W-1:0]   hdiff;
  logic signed [UNW_W-1:0]    wrap_ext, wrap_off, unw;
  logic signed [ERR_W-1:0]    err_sat;
  logic signed [ACC_W-1:0]    rnd, isum, lim_s, clamp1, clamp2, m_d, q1;
  logic [KD_W-1:0]            kdk;
  logic [EL_W:0]              div_sh;
  logic [EL_W+1:0]            div_trial;
  logic                       div_ge;
  logic signed [DIV_W:0]      deriv;
  logic signed [SUM_W-1:0]    sum_w;
  logic signed [OUT_W:0]      dl_w, dr_w;
  logic                       in_xfer, out_xfer;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // quadrant snap
  assign h_in_ext = HCMP_W'(in_ch.data.heading);
  always_comb begin
    if (h_in_ext > DEG45 && h_in_ext <= DEG135) begin
      snap_tgt = TGT_90;
    end else if (h_in_ext > DEG135 && h_in_ext <= DEG225) begin
      snap_tgt = TGT_180;
    end else if (h_in_ext > DEG225 && h_in_ext <= DEG315) begin
      snap_tgt = TGT_270;
    end else begin
      snap_tgt = '0;
    end
  end

  assign hdiff = signed'(h_in_ext) - signed'(HCMP_W'(last_r));

  // unwrapped heading: 360 = 256 + 64 + 32 + 8
  assign wrap_ext = UNW_W'(wrap_r);
  assign wrap_off = ((wrap_ext <<< 8) + (wrap_ext <<< 6) + (wrap_ext <<< 5)
                    + (wrap_ext <<< 3)) <<< HEADING_FRAC_BITS;
  assign unw = signed'(UNW_W'(h_r)) + wrap_off - signed'(UNW_W'(tgt_r));
  assign err_sat = (unw > ERR_HI) ? ERR_MIN[ERR_W-1:0] ^ {ERR_W{1'b1}} :
                   (unw < ERR_LO) ? ERR_MIN[ERR_W-1:0] : unw[ERR_W-1:0];

  // kd * 1000 = kd * 1024 - kd * 16 - kd * 8
  assign kdk = (KD_W'(gain_deriv_r) << 10) - (KD_W'(gain_deriv_r) << 4)
               - (KD_W'(gain_deriv_r) << 3);

  assign rnd    = (acc_r + HALF_Q) >>> SHIFT_Q;
  assign isum   = ACC_W'(integ_r) + rnd;
  assign lim_s  = signed'(ACC_W'(integ_limit_r));
  assign clamp1 = (isum > lim_s) ? lim_s : isum;
  assign clamp2 = (clamp1 < -lim_s) ? -lim_s : clamp1;

  assign m_d = acc_r + (signed'(ACC_W'(el_r)) <<< (SHIFT_Q - 1));
  assign q1  = m_d >>> SHIFT_Q;

  assign div_sh    = {rem_r, dvd_r[DIV_W-1]};
  assign div_trial = {1'b0, div_sh} - {2'b00, el_r};
  assign div_ge    = !div_trial[EL_W+1];

  assign deriv = neg_r ? signed'(~{1'b0, dvd_r}) : signed'({1'b0, dvd_r});
  assign sum_w = SUM_W'(pi_r) + SUM_W'(deriv);

  assign dl_w = (OUT_W + 1)'(ONE_Q13) + (OUT_W + 1)'(corr_r);
  assign dr_w = (OUT_W + 1)'(ONE_Q13) - (OUT_W + 1)'(corr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r   <= '0;
      gain_integ_r  <= '0;
      gain_deriv_r  <= '0;
      integ_limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GAIN_PROP:   gain_prop_r   <= cfg_wdata;
        CFG_GAIN_INTEG:  gain_integ_r  <= cfg_wdata;
        CFG_GAIN_DERIV:  gain_deriv_r  <= cfg_wdata;
        CFG_INTEG_LIMIT: integ_limit_r <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    tgt_nxt       = tgt_r;
    last_nxt      = last_r;
    wrap_nxt      = wrap_r;
    integ_nxt     = integ_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r;
    h_nxt         = h_r;
    el_nxt        = el_r;
    start_nxt     = start_r;
    err_nxt       = err_r;
    d_nxt         = d_r;
    mc_nxt        = mc_r;
    mp_nxt        = mp_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    prop_nxt      = prop_r;
    pi_nxt        = pi_r;
    neg_nxt       = neg_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    corr_nxt      = corr_r;
    out_nxt       = out_r;

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.data.cmd == CMD_START) begin
            tgt_nxt   = snap_tgt;
            last_nxt  = LAST_W'(snap_tgt);
            wrap_nxt  = '0;
            integ_nxt = '0;
            corr_nxt  = '0;
            start_nxt = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            h_nxt     = in_ch.data.heading;
            el_nxt    = (in_ch.data.elapsed_ms == '0) ? EL_W'(1) : in_ch.data.elapsed_ms;
            last_nxt  = LAST_W'(in_ch.data.heading);
            start_nxt = 1'b0;
            if (hdiff > DEG180_S) begin
              wrap_nxt = wrap_r - WRAP_BITS'(1);
            end else if (hdiff < -DEG180_S) begin
              wrap_nxt = wrap_r + WRAP_BITS'(1);
            end
            state_nxt = S_ERR;
          end
        end
      end
      S_ERR: begin
        err_nxt   = err_sat;
        d_nxt     = DIFF_W'(err_sat) - DIFF_W'(prev_r);
        prev_nxt  = err_sat;
        mc_nxt    = ACC_W'(err_sat);
        mp_nxt    = KD_W'(gain_prop_r);
        acc_nxt   = '0;
        cnt_nxt   = CNT_W'(GAIN_W - 1);
        op_nxt    = OP_PROP;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        acc_nxt = mp_r[0] ? acc_r + mc_r : acc_r;
        mc_nxt  = mc_r <<< 1;
        mp_nxt  = mp_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        case (op_r)
          OP_PROP: begin
            prop_nxt  = rnd;
            mc_nxt    = ACC_W'(err_r);
            mp_nxt    = KD_W'(gain_integ_r);
            acc_nxt   = '0;
            cnt_nxt   = CNT_W'(GAIN_W - 1);
            op_nxt    = OP_INTEG;
            state_nxt = S_MUL;
          end
          OP_INTEG: begin
            integ_nxt = clamp2[OUT_W-1:0];
            pi_nxt    = prop_r + clamp2;
            mc_nxt    = ACC_W'(d_r);
            mp_nxt    = kdk;
            acc_nxt   = '0;
            cnt_nxt   = CNT_W'(KD_W - 1);
            op_nxt    = OP_DERIV;
            state_nxt = S_MUL;
          end
          OP_DERIV: begin
            // floor division of a negative value: divide its complement
            neg_nxt   = q1[ACC_W-1];
            dvd_nxt   = q1[ACC_W-1] ? ~q1[DIV_W-1:0] : q1[DIV_W-1:0];
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(DIV_W - 1);
            state_nxt = S_DIV;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIV: begin
        rem_nxt = div_ge ? div_trial[EL_W-1:0] : div_sh[EL_W-1:0];
        dvd_nxt = {dvd_r[DIV_W-2:0], div_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        corr_nxt  = (sum_w > SUM_HI) ? CORR_MAX[OUT_W-1:0] :
                    (sum_w < SUM_LO) ? CORR_MIN[OUT_W-1:0] : sum_w[OUT_W-1:0];
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt.correction    = corr_r;
          out_nxt.drive_left    = (dl_w > DRV_HI) ? CORR_MAX[OUT_W-1:0] :
                                  (dl_w < DRV_LO) ? CORR_MIN[OUT_W-1:0] : dl_w[OUT_W-1:0];
          out_nxt.drive_right   = (dr_w > DRV_HI) ? CORR_MAX[OUT_W-1:0] :
                                  (dr_w < DRV_LO) ? CORR_MIN[OUT_W-1:0] : dr_w[OUT_W-1:0];
          out_nxt.heading_error = start_r ? '0 : err_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_PROP;
      tgt_r       <= '0;
      last_r      <= '0;
      wrap_r      <= '0;
      integ_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      tgt_r       <= tgt_nxt;
      last_r      <= last_nxt;
      wrap_r      <= wrap_nxt;
      integ_r     <= integ_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r     <= h_nxt;
    el_r    <= el_nxt;
    start_r <= start_nxt;
    err_r   <= err_nxt;
    d_r     <= d_nxt;
    mc_r    <= mc_nxt;
    mp_r    <= mp_nxt;
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
    prop_r  <= prop_nxt;
    pi_r    <= pi_nxt;
    neg_r   <= neg_nxt;
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    corr_r  <= corr_nxt;
    out_r   <= out_nxt;
  end

endmodule

>>> tb/heading_hold_pid_checker.sv
`timescale 1ns / 1ps
module heading_hold_pid_checker #(
  parameter int WRAP_BITS         = 8,
  parameter int HEADING_FRAC_BITS = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hhp_in_if                             in_ch,
  hhp_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [hhp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [hhp_pkg::GAIN_W-1:0]    cfg_wdata,
  output int                            fail_count,
  output int                            outstanding
);
  import hhp_pkg::*;

  localparam int     SHIFT_Q = 3 + HEADING_FRAC_BITS;
  localparam longint DEG     = longint'(1) << HEADING_FRAC_BITS;
  localparam int     PRINT_MAX = 40;

  logic [GAIN_W-1:0]    kp, ki, kd;
  logic [LIM_W-1:0]     ilim;
  longint               tgt_hdg, prev_hdg, integ_q13, last_err;
  logic [WRAP_BITS-1:0] wraps;
  hhp_out_t             expected_q[$];

  function automatic longint clip(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Q(16+frac) product down to Q2.13, nearest with ties up
  function automatic longint round_q13(longint x);
    return (x + (longint'(1) <<< (SHIFT_Q - 1))) >>> SHIFT_Q;
  endfunction

  function automatic hhp_out_t predict_pid(hhp_in_t it);
    hhp_out_t r;
    longint h, el, err, prop, deriv, corr, num, den, n2, d2, q, lim;
    h  = longint'(it.heading);
    el = longint'(it.elapsed_ms);
    if (it.cmd == CMD_START) begin
      if (h > 45 * DEG && h <= 135 * DEG) begin
        tgt_hdg = 90 * DEG;
      end else if (h > 135 * DEG && h <= 225 * DEG) begin
        tgt_hdg = 180 * DEG;
      end else if (h > 225 * DEG && h <= 315 * DEG) begin
        tgt_hdg = 270 * DEG;
      end else begin
        tgt_hdg = 0;
      end
      prev_hdg  = tgt_hdg;
      wraps     = '0;
      integ_q13 = 0;
      r.correction    = '0;
      r.drive_left    = ONE_Q13;
      r.drive_right   = ONE_Q13;
      r.heading_error = '0;
      return r;
    end

    if (h - prev_hdg > 180 * DEG) begin
      wraps = wraps - 1'b1;
    end else if (h - prev_hdg < -180 * DEG) begin
      wraps = wraps + 1'b1;
    end
    prev_hdg = h;

    err  = clip(h + longint'($signed(wraps)) * 360 * DEG - tgt_hdg, ERR_W);
    prop = round_q13(err * longint'(kp));

    integ_q13 = integ_q13 + round_q13(err * longint'(ki));
    lim = longint'(ilim);
    if (integ_q13 > lim) integ_q13 = lim;
    if (integ_q13 < -lim) integ_q13 = -lim;

    if (el == 0) el = 1;
    num = (err - last_err) * longint'(kd) * 1000;
    den = el * (longint'(1) <<< SHIFT_Q);
    n2  = 2 * num + den;
    d2  = 2 * den;
    q   = n2 / d2;
    if (n2 % d2 != 0 && n2 < 0) q = q - 1;
    deriv    = q;
    last_err = err;

    corr = clip(prop + integ_q13 + deriv, OUT_W);
    r.correction    = corr[OUT_W-1:0];
    r.drive_left    = OUT_W'(clip(longint'(ONE_Q13) + corr, OUT_W));
    r.drive_right   = OUT_W'(clip(longint'(ONE_Q13) - corr, OUT_W));
    r.heading_error = err[ERR_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (fail_count < PRINT_MAX) $display("%0t checker: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    hhp_out_t want, got;
    if (!rst_n) begin
      kp = '0;
      ki = '0;
      kd = '0;
      ilim = '0;
      tgt_hdg = 0;
      prev_hdg = 0;
      integ_q13 = 0;
      last_err = 0;
      wraps = '0;
      expected_q.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_GAIN_PROP:   kp = cfg_wdata;
          CFG_GAIN_INTEG:  ki = cfg_wdata;
          CFG_GAIN_DERIV:  kd = cfg_wdata;
          CFG_INTEG_LIMIT: ilim = cfg_wdata[LIM_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected, correction %0d",
                                    got.correction));
        end else begin
          want = expected_q.pop_front();
          if (got.correction !== want.correction)
            report_mismatch($sformatf("correction got %0d expected %0d",
                                      got.correction, want.correction));
          if (got.drive_left !== want.drive_left)
            report_mismatch($sformatf("drive_left got %0d expected %0d",
                                      got.drive_left, want.drive_left));
          if (got.drive_right !== want.drive_right)
            report_mismatch($sformatf("drive_right got %0d expected %0d",
                                      got.drive_right, want.drive_right));
          if (got.heading_error !== want.heading_error)
            report_mismatch($sformatf("heading_error got %0d expected %0d",
                                      got.heading_error, want.heading_error));
        end
      end
      if (in_ch.valid && in_ch.ready) expected_q.push_back(predict_pid(in_ch.data));
      outstanding <= expected_q.size();
    end
  end

endmodule

>>> tb/heading_hold_pid_tb.sv
`timescale 1ns / 1ps
module heading_hold_pid_tb;
  import hhp_pkg::*;

  localparam int WRAP_BITS         = 8;
  localparam int HEADING_FRAC_BITS = 6;
  localparam int ONE_DEG       = 1 << HEADING_FRAC_BITS;
  localparam int FULL_TURN     = 360 * ONE_DEG;
  localparam int HEAD_MAX      = (1 << HEAD_W) - 1;
  localparam int EL_MAX        = (1 << EL_W) - 1;
  localparam int GAIN_MAX      = (1 << GAIN_W) - 1;
  localparam int LIM_MAX       = (1 << LIM_W) - 1;
  localparam int IDLE_LIMIT    = 5000;
  localparam int HOLD_CYCLES   = 600;
  localparam int HOLD_AFTER    = 300;
  localparam int SETTLE_CYCLES = 150;
  localparam int PHASE_ITEMS   = 280;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [GAIN_W-1:0]    cfg_wdata = '0;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  int items_sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  bit calm = 1'b0;

  hhp_in_if  in_ch ();
  hhp_out_if out_ch ();

  heading_hold_pid #(
    .WRAP_BITS        (WRAP_BITS),
    .HEADING_FRAC_BITS(HEADING_FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  heading_hold_pid_checker #(
    .WRAP_BITS        (WRAP_BITS),
    .HEADING_FRAC_BITS(HEADING_FRAC_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("heading_hold_pid_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off to back up the block
  initial begin
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(18, 1)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
    end
  end

  task automatic send_item(input logic cmd, input int heading, input int elapsed);
    hhp_in_t it;
    it.cmd        = cmd;
    it.heading    = heading[HEAD_W-1:0];
    it.elapsed_ms = elapsed[EL_W-1:0];
    if (!calm && $urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_gains(input int kp, input int ki, input int kd, input int lim);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_GAIN_PROP;
    cfg_wdata <= kp[GAIN_W-1:0];
    @(posedge clk);
    cfg_idx   <= CFG_GAIN_INTEG;
    cfg_wdata <= ki[GAIN_W-1:0];
    @(posedge clk);
    cfg_idx   <= CFG_GAIN_DERIV;
    cfg_wdata <= kd[GAIN_W-1:0];
    @(posedge clk);
    cfg_idx   <= CFG_INTEG_LIMIT;
    cfg_wdata <= lim[GAIN_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_elapsed();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(50, 1);
    if (r < 75) return 0;
    if (r < 88) return $urandom_range(1000);
    return $urandom_range(EL_MAX);
  endfunction

  function automatic int pick_start_heading();
    if ($urandom_range(9) == 0) return $urandom_range(HEAD_MAX);
    return $urandom_range(FULL_TURN - 1);
  endfunction

  // small drift mostly, sometimes a big jump or an out-of-range reading
  function automatic int next_heading(int cur);
    int r, v;
    r = $urandom_range(99);
    if (r < 5) return $urandom_range(HEAD_MAX);
    if (r < 80) v = cur + $urandom_range(1200) - 600;
    else v = cur + $urandom_range(22000) - 11000;
    if (v < 0) v += FULL_TURN;
    if (v >= FULL_TURN) v -= FULL_TURN;
    return v;
  endfunction

  task automatic hold_run(input int n);
    int cur, raw;
    cur = pick_start_heading();
    send_item(CMD_START, cur, pick_elapsed());
    cur = cur % FULL_TURN;
    repeat (n) begin
      raw = next_heading(cur);
      send_item(CMD_SAMPLE, raw, pick_elapsed());
      cur = raw % FULL_TURN;
    end
  endtask

  // steps just under half a turn: a wrap at most every second sample
  task automatic spin_run(input int n);
    int  cur;
    bit  up;
    cur = $urandom_range(FULL_TURN - 1);
    up  = $urandom_range(1);
    send_item(CMD_START, cur, pick_elapsed());
    repeat (n) begin
      if (up) cur = (cur + $urandom_range(11500, 9000)) % FULL_TURN;
      else cur = (cur + FULL_TURN - $urandom_range(11500, 9000)) % FULL_TURN;
      send_item(CMD_SAMPLE, cur, pick_elapsed());
    end
  endtask

  task automatic noise_run(input int n);
    repeat (n) begin
      send_item($urandom_range(1) ? CMD_SAMPLE : CMD_START, $urandom_range(HEAD_MAX),
                $urandom_range(EL_MAX));
    end
  endtask

  task automatic run_phase(input int count, input bit long_spin);
    int first, kind;
    first = items_sent;
    if (long_spin) spin_run(300);
    while (items_sent - first < count) begin
      kind = $urandom_range(99);
      if (kind < 72) hold_run($urandom_range(60, 5));
      else if (kind < 80) spin_run($urandom_range(120, 30));
      else noise_run($urandom_range(10, 1));
    end
    drain();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    rst_n       <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_gains(65536, 6554, 3277, 4096);
    // quadrant snap boundaries, top of the 15-bit range
    send_item(CMD_START, 0, 0);
    send_item(CMD_START, 45 * ONE_DEG, 7);
    send_item(CMD_START, 45 * ONE_DEG + 1, EL_MAX);
    send_item(CMD_START, 135 * ONE_DEG, 1);
    send_item(CMD_START, 135 * ONE_DEG + 1, 0);
    send_item(CMD_START, 225 * ONE_DEG, 3);
    send_item(CMD_START, 225 * ONE_DEG + 1, 9);
    send_item(CMD_START, 315 * ONE_DEG, 20);
    send_item(CMD_START, 315 * ONE_DEG + 1, 2);
    send_item(CMD_START, FULL_TURN - 1, 5);
    send_item(CMD_START, HEAD_MAX, 11);
    // wraps both ways, zero and max elapsed, heading past 360 in a sample
    send_item(CMD_SAMPLE, 23000, 0);
    send_item(CMD_SAMPLE, 100, EL_MAX);
    send_item(CMD_SAMPLE, HEAD_MAX, 1);
    send_item(CMD_SAMPLE, 0, 50);
    send_item(CMD_START, 9000, 10);
    send_item(CMD_SAMPLE, 90 * ONE_DEG, 10);
    send_item(CMD_SAMPLE, 270 * ONE_DEG, 20);
    send_item(CMD_SAMPLE, 270 * ONE_DEG + 1, 20);
    send_item(CMD_SAMPLE, 90 * ONE_DEG, 20);
    drain();

    gap_pct = 15;
    stall_pct = 3;
    load_gains(0, 0, 0, 0);
    run_phase(PHASE_ITEMS, 1'b0);

    gap_pct = 50;
    stall_pct = 10;
    load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, LIM_MAX);
    run_phase(PHASE_ITEMS, 1'b1);

    gap_pct = 0;
    stall_pct = 0;
    load_gains($urandom_range(GAIN_MAX), $urandom_range(GAIN_MAX), $urandom_range(GAIN_MAX),
               $urandom_range(LIM_MAX));
    run_phase(PHASE_ITEMS, 1'b0);

    gap_pct = 30;
    stall_pct = 6;
    load_gains($urandom_range(4096), $urandom_range(512), $urandom_range(256), LIM_MAX);
    run_phase(PHASE_ITEMS, 1'b0);

    gap_pct = 10;
    stall_pct = 1;
    load_gains($urandom_range(8192), GAIN_MAX, $urandom_range(GAIN_MAX), 0);
    run_phase(PHASE_ITEMS, 1'b0);

    calm = 1'b1;
    load_gains($urandom_range(GAIN_MAX), $urandom_range(65536), $urandom_range(GAIN_MAX),
               $urandom_range(LIM_MAX));
    run_phase(PHASE_ITEMS, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("heading_hold_pid_tb: PASS");
    end else begin
      $display("heading_hold_pid_tb: FAIL");
    end
    $finish;
  end

endmodule
